>>> hdl/mwt_pkg.sv
// Package for the memory watchpoint table: request kinds, entry and result types.
// Used by mwt_match and memory_watchpoint_table_core. No dependencies.
`default_nettype none

package mwt_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned HIT_IDX_W       = 4;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_ACCESS = 2'd2
  } kind_e;

  typedef struct packed {
    logic brk;
    logic log;
    logic wr;
    logic rd;
    logic rng;
  } flags_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    flags_t            flags;
  } entry_t;

  typedef struct packed {
    logic                 done_ok;
    logic                 table_full;
    logic                 hit;
    logic [HIT_IDX_W-1:0] hit_index;
    logic                 log_event;
    logic                 break_event;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/memory_watchpoint_table_core.sv
// Top level of the memory watchpoint table: request register, table, result register.
// Depends on mwt_pkg and mwt_match.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o: kind_i selects add, remove or access check.
//   Each request yields exactly one result on out_valid_o/out_ready_i.
//   A request passes the request register, then the result register; throughput is
//   one request per cycle while the receiver does not stall. The request register feeds the
//   comparator bank and priority encoders, and the table update and the result register
//   load in the same cycle, so the next request always sees the updated table.
//   Entries are kept in insertion order; remove closes the gap by shifting later
//   entries down one slot.
//   Reset clears the entry count and both valid flags; entry contents are not reset
//   and lanes at or above the count are ignored.
//   When the receiver stalls, the result holds, the request register fills, and
//   in_ready_o drops until the result is taken. Kind 3 changes nothing and returns
//   an all-zero result.
`default_nettype none

module memory_watchpoint_table_core #(
  parameter int unsigned NUM_ENTRIES = mwt_pkg::NUM_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic [mwt_pkg::ADDR_W-1:0]          address_i,
  input  logic [mwt_pkg::ADDR_W-1:0]          end_address_i,
  input  logic                                is_range_i,
  input  logic                                on_read_i,
  input  logic                                on_write_i,
  input  logic                                log_on_hit_i,
  input  logic                                break_on_hit_i,
  input  logic                                is_write_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                done_ok_o,
  output logic                                table_full_o,
  output logic                                hit_o,
  output logic [mwt_pkg::HIT_IDX_W-1:0]       hit_index_o,
  output logic                                log_event_o,
  output logic                                break_event_o
);

  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);

  logic                        req_valid_q, req_valid_d;
  logic [1:0]                  req_kind_q;
  logic [mwt_pkg::ADDR_W-1:0]  req_addr_q;
  logic [mwt_pkg::ADDR_W-1:0]  req_end_q;
  mwt_pkg::flags_t             req_flags_q;
  logic                        req_wr_q;

  logic                        res_valid_q, res_valid_d;
  mwt_pkg::result_t            res_q, res_d;

  mwt_pkg::entry_t             ent_q [NUM_ENTRIES];
  mwt_pkg::entry_t             ent_d [NUM_ENTRIES];
  mwt_pkg::entry_t             new_ent;
  logic [CNT_W-1:0]            cnt_q, cnt_d;

  logic                        in_fire;
  logic                        proc_fire;

  logic                        cover_hit;
  logic [IDX_W-1:0]            cover_pos;
  mwt_pkg::flags_t             cover_flags;
  logic                        start_hit;
  logic [IDX_W-1:0]            start_pos;
  logic [IDX_W+mwt_pkg::HIT_IDX_W-1:0] pos_ext;
  logic                        dir_ok;

  assign proc_fire  = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || proc_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_fire) begin
      req_valid_d = 1'b1;
    end else if (proc_fire) begin
      req_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_kind_q        <= kind_i;
      req_addr_q        <= address_i;
      req_end_q         <= end_address_i;
      req_flags_q.rng   <= is_range_i;
      req_flags_q.rd    <= on_read_i;
      req_flags_q.wr    <= on_write_i;
      req_flags_q.log   <= log_on_hit_i;
      req_flags_q.brk   <= break_on_hit_i;
      req_wr_q          <= is_write_i;
    end
  end

  mwt_match #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_match (
    .entries_i    (ent_q),
    .count_i      (cnt_q),
    .addr_i       (req_addr_q),
    .cover_hit_o  (cover_hit),
    .cover_pos_o  (cover_pos),
    .cover_flags_o(cover_flags),
    .start_hit_o  (start_hit),
    .start_pos_o  (start_pos)
  );

  assign pos_ext = {{mwt_pkg::HIT_IDX_W{1'b0}}, cover_pos};
  assign dir_ok  = req_wr_q ? cover_flags.wr : cover_flags.rd;

  always_comb begin
    new_ent.start_addr = req_addr_q;
    new_ent.end_addr   = req_flags_q.rng ? req_end_q : req_addr_q;
    new_ent.flags      = req_flags_q;
  end

  always_comb begin
    res_d = '0;
    ent_d = ent_q;
    cnt_d = cnt_q;
    unique case (req_kind_q)
      mwt_pkg::KIND_ADD: begin
        if (cover_hit) begin
          res_d.hit       = 1'b1;
          res_d.hit_index = pos_ext[mwt_pkg::HIT_IDX_W-1:0];
        end else if (cnt_q >= CNT_W'(NUM_ENTRIES)) begin
          res_d.table_full = 1'b1;
        end else begin
          res_d.done_ok = 1'b1;
          ent_d[cnt_q[IDX_W-1:0]] = new_ent;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      mwt_pkg::KIND_REMOVE: begin
        if (start_hit) begin
          res_d.done_ok = 1'b1;
          for (int j = 0; j < NUM_ENTRIES - 1; j++) begin
            if (IDX_W'(j) >= start_pos) begin
              ent_d[j] = ent_q[j+1];
            end
          end
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      mwt_pkg::KIND_ACCESS: begin
        if (cover_hit) begin
          res_d.hit         = 1'b1;
          res_d.hit_index   = pos_ext[mwt_pkg::HIT_IDX_W-1:0];
          res_d.log_event   = dir_ok && cover_flags.log;
          res_d.break_event = dir_ok && cover_flags.brk;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (proc_fire) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      ent_q <= ent_d;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (proc_fire) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign done_ok_o     = res_q.done_ok;
  assign table_full_o  = res_q.table_full;
  assign hit_o         = res_q.hit;
  assign hit_index_o   = res_q.hit_index;
  assign log_event_o   = res_q.log_event;
  assign break_event_o = res_q.break_event;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_ENTRIES))
    else $error("entry count exceeds table depth");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (req_kind_q == mwt_pkg::KIND_ADD) && res_d.done_ok
    |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("accepted add did not grow the table");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (req_kind_q == mwt_pkg::KIND_REMOVE) && res_d.done_ok
    |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("successful remove did not shrink the table");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res_d.table_full |-> cnt_q == CNT_W'(NUM_ENTRIES) && !cover_hit)
    else $error("table full reported below depth");

  a_events_need_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (res_d.log_event || res_d.break_event)
    |-> res_d.hit && (req_kind_q == mwt_pkg::KIND_ACCESS))
    else $error("event raised without an access hit");

endmodule

`default_nettype wire

>>> hdl/mwt_match.sv
// Parallel comparators and priority encoders over the watchpoint entries.
// Depends on mwt_pkg for the entry and flag types.
`default_nettype none

module mwt_match #(
  parameter int unsigned NUM_ENTRIES = mwt_pkg::NUM_ENTRIES_DEF,
  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1)
) (
  input  mwt_pkg::entry_t             entries_i [NUM_ENTRIES],
  input  logic [CNT_W-1:0]            count_i,
  input  logic [mwt_pkg::ADDR_W-1:0]  addr_i,
  output logic                        cover_hit_o,
  output logic [IDX_W-1:0]            cover_pos_o,
  output mwt_pkg::flags_t             cover_flags_o,
  output logic                        start_hit_o,
  output logic [IDX_W-1:0]            start_pos_o
);

  logic [NUM_ENTRIES-1:0] cov;
  logic [NUM_ENTRIES-1:0] st;
  logic [NUM_ENTRIES-1:0] cov_oh;
  logic [NUM_ENTRIES-1:0] st_oh;

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (CNT_W'(i) < count_i) begin
        st[i] = (entries_i[i].start_addr == addr_i);
        if (entries_i[i].flags.rng) begin
          cov[i] = (addr_i >= entries_i[i].start_addr) && (addr_i <= entries_i[i].end_addr);
        end else begin
          cov[i] = st[i];
        end
      end else begin
        st[i]  = 1'b0;
        cov[i] = 1'b0;
      end
    end
  end

  assign cov_oh = cov & (~cov + NUM_ENTRIES'(1));
  assign st_oh  = st & (~st + NUM_ENTRIES'(1));

  assign cover_hit_o = |cov;
  assign start_hit_o = |st;

  always_comb begin
    cover_pos_o   = '0;
    start_pos_o   = '0;
    cover_flags_o = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (cov_oh[i]) begin
        cover_pos_o   = cover_pos_o | IDX_W'(i);
        cover_flags_o = cover_flags_o | entries_i[i].flags;
      end
      if (st_oh[i]) begin
        start_pos_o = start_pos_o | IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
